[rtl/core/c_subset_lexer_assert.svh]
// Assertion macros for the lexer block.
// Needs clk and rst_n in the including scope.
`ifndef C_SUBSET_LEXER_ASSERT_SVH
`define C_SUBSET_LEXER_ASSERT_SVH
// same-cycle implication
`define CSL_IMPLY(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("lexer check failed");
// next-cycle implication
`define CSL_NEXT(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("lexer check failed");
`endif

[rtl/core/c_lex_pkg.sv]
// Constants, codes and character tables of the lexer.
// No dependencies.
package c_lex_pkg;
  localparam int MAX_TEXT = 32;
  localparam int AW  = $clog2(MAX_TEXT);
  localparam int TLW = $clog2(MAX_TEXT + 2);
  localparam int KW_N = 18;

  localparam logic [2:0] M_IDLE = 3'd0, M_NORMAL = 3'd1, M_IDENT = 3'd2, M_NUMBER = 3'd3,
                         M_LINE_CMT = 3'd4, M_BLOCK_CMT = 3'd5, M_SKIP_NORMAL = 3'd6,
                         M_SKIP_BLOCK = 3'd7;

  localparam logic [5:0] K_EOF = 6'd0, K_INT = 6'd1, K_IDENT = 6'd2, K_KEYWORD0 = 6'd3,
                         K_TWO0 = 6'd21, K_ONE0 = 6'd31, K_BAD = 6'd50, K_OPEN_CMT = 6'd51;

  localparam logic [7:0] CH_LF = 8'h0A;

  localparam logic [71:0] KW_STR [KW_N] = '{
    72'("int"), 72'("char"), 72'("short"), 72'("long"), 72'("return"), 72'("if"),
    72'("else"), 72'("while"), 72'("for"), 72'("break"), 72'("continue"), 72'("do"),
    72'("goto"), 72'("switch"), 72'("case"), 72'("default"), 72'("_assert"),
    72'("_print")};

  localparam logic [15:0] TWO_STR [10] = '{"==", "!=", "<=", ">=", "&&", "||", "+=", "-=",
                                           "++", "--"};
  localparam logic [7:0] ONE_STR [19] = '{"(", ")", "{", "}", "[", "]", ";", "-", "+", "*",
                                          "/", "=", ",", "!", "<", ">", "%", ":", "&"};

  typedef logic [KW_N-1:0] kw_mask_t;

  function automatic logic [3:0] kw_len(input int k);
    logic [3:0] n;
    n = '0;
    for (int j = 0; j < 9; j++)
      if (KW_STR[k][8*j +: 8] != 8'd0) n = n + 4'd1;
    return n;
  endfunction

  function automatic logic [7:0] kw_char(input int k, input logic [3:0] i);
    logic [3:0] n;
    logic [7:0] ch;
    n = kw_len(k);
    ch = 8'd0;
    for (int j = 0; j < 9; j++)
      if (i < n && 4'(j) == n - 4'd1 - i) ch = KW_STR[k][8*j +: 8];
    return ch;
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_ident(input logic [7:0] c);
    return is_alpha(c) || is_digit(c) || c == "_";
  endfunction

  // keyword kind when the text matches, else K_EOF
  function automatic logic [5:0] kw_hit(input kw_mask_t m, input logic [TLW-1:0] len);
    logic [5:0] r;
    r = K_EOF;
    for (int k = KW_N - 1; k >= 0; k--)
      if (m[k] && TLW'(kw_len(k)) == len) r = K_KEYWORD0 + 6'(k);
    return r;
  endfunction

  function automatic logic [5:0] two_code(input logic [7:0] c, input logic [7:0] nx);
    logic [5:0] r;
    r = K_EOF;
    for (int k = 9; k >= 0; k--)
      if (TWO_STR[k] == {c, nx}) r = K_TWO0 + 6'(k);
    return r;
  endfunction

  function automatic logic [5:0] one_code(input logic [7:0] c);
    logic [5:0] r;
    r = K_EOF;
    for (int k = 18; k >= 0; k--)
      if (ONE_STR[k] == c) r = K_ONE0 + 6'(k);
    return r;
  endfunction

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction
endpackage

[rtl/core/c_lex_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module c_lex_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

[rtl/core/c_subset_lexer.sv]
// Streaming lexer for a small C subset: top level, control and output register.
// Depends on c_lex_pkg, c_lex_ram and c_subset_lexer_assert.svh.
//
// Usage:
// in_* carries one source byte per request; byte 0 ends the text, flushes any
// pending token, emits an eof token and returns the lexer to its reset state.
// out_* carries result items: tdata holds kind, start line, start column and
// text character; tlast marks the final item of a token.
// One byte is held as lookahead, so a token appears once the byte after it
// has been taken. A byte is taken, then its items are issued in order from
// the output register; the next byte is taken only after the last item has
// been loaded and the sequencer has returned to idle.
// Identifier and integer text is replayed from the text RAM, waiting for the
// registered read data before each character; a text token that starts on
// the byte ending such a token gets its RAM write after that replay.
// Reset (rst_n low, synchronous) clears the lexer state; the text RAM needs no
// clearing. When the receiver stalls the output register holds its item and
// the sequencer waits; no item is lost.
module c_subset_lexer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] source_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [5:0] token_kind, [21:6] start_line,
                                  // [37:22] start_column, [45:38] text_char
  output logic        out_tlast   // last_of_token
);
  import c_lex_pkg::*;

  localparam logic ST_IDLE = 1'b0, ST_RUN = 1'b1;

  logic st_r, st_nxt;
  logic [2:0] mode_r, mode_nxt;
  logic [7:0] held_r, held_nxt;
  logic [TLW-1:0] tlen_r, tlen_nxt;
  kw_mask_t kwm_r, kwm_nxt;
  logic [15:0] tok_line_r, tok_line_nxt, tok_col_r, tok_col_nxt;
  logic [15:0] cur_line_r, cur_line_nxt, cur_col_r, cur_col_nxt;

  logic f_act_r, f_act_nxt, f_iskw_r, f_iskw_nxt;
  logic [5:0] f_kind_r, f_kind_nxt;
  logic [TLW-1:0] f_cnt_r, f_cnt_nxt, f_idx_r, f_idx_nxt;
  logic [15:0] f_line_r, f_line_nxt, f_col_r, f_col_nxt;
  logic rd_ok_r, rd_ok_nxt;
  logic pw_r, pw_nxt;
  logic [7:0] pw_data_r, pw_data_nxt;

  logic s_act_r, s_act_nxt;
  logic [5:0] s_kind_r, s_kind_nxt;
  logic [7:0] s_char_r, s_char_nxt;
  logic [15:0] s_line_r, s_line_nxt, s_col_r, s_col_nxt;
  logic e_act_r, e_act_nxt;
  logic [15:0] e_line_r, e_line_nxt, e_col_r, e_col_nxt;

  logic out_valid_r, out_valid_nxt, out_last_r, out_last_nxt;
  logic [5:0] out_kind_r, out_kind_nxt;
  logic [15:0] out_line_r, out_line_nxt, out_col_r, out_col_nxt;
  logic [7:0] out_char_r, out_char_nxt;

  logic ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0] ram_wdata, ram_rdata;

  logic in_acc, out_free, proceed, do_flush, started;
  logic [7:0] c, nx;
  logic [5:0] kw, tc, oc;
  logic [2:0] m;

  c_lex_ram #(.WIDTH(8), .DEPTH(MAX_TEXT)) u_text (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(f_idx_r[AW-1:0]), .rdata(ram_rdata)
  );

  assign in_tready = (st_r == ST_IDLE);
  assign in_acc = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;
  assign c = held_r;
  assign nx = in_tdata;

  always_comb begin
    st_nxt = st_r; mode_nxt = mode_r; held_nxt = held_r; tlen_nxt = tlen_r; kwm_nxt = kwm_r;
    tok_line_nxt = tok_line_r; tok_col_nxt = tok_col_r;
    cur_line_nxt = cur_line_r; cur_col_nxt = cur_col_r;
    f_act_nxt = f_act_r; f_iskw_nxt = f_iskw_r; f_kind_nxt = f_kind_r;
    f_cnt_nxt = f_cnt_r; f_idx_nxt = f_idx_r; f_line_nxt = f_line_r; f_col_nxt = f_col_r;
    rd_ok_nxt = rd_ok_r; pw_nxt = pw_r; pw_data_nxt = pw_data_r;
    s_act_nxt = s_act_r; s_kind_nxt = s_kind_r; s_char_nxt = s_char_r;
    s_line_nxt = s_line_r; s_col_nxt = s_col_r;
    e_act_nxt = e_act_r; e_line_nxt = e_line_r; e_col_nxt = e_col_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_last_nxt = out_last_r; out_kind_nxt = out_kind_r; out_line_nxt = out_line_r;
    out_col_nxt = out_col_r; out_char_nxt = out_char_r;
    ram_we = 1'b0; ram_waddr = '0; ram_wdata = c;
    proceed = 1'b0; do_flush = 1'b0; started = 1'b0; m = mode_r;
    kw = K_EOF; tc = two_code(c, nx); oc = one_code(c);

    if (in_acc) begin
      st_nxt = ST_RUN; rd_ok_nxt = 1'b0; f_idx_nxt = '0;
      f_act_nxt = 1'b0; s_act_nxt = 1'b0; e_act_nxt = 1'b0; pw_nxt = 1'b0;
      pw_data_nxt = c;
      if (mode_r == M_IDLE) begin
        if (nx == 8'd0) begin
          e_act_nxt = 1'b1; e_line_nxt = cur_line_r; e_col_nxt = cur_col_r;
        end else begin
          held_nxt = nx; mode_nxt = M_NORMAL;
        end
      end else begin
        case (mode_r)
          M_SKIP_NORMAL: m = M_NORMAL;
          M_SKIP_BLOCK:  m = M_BLOCK_CMT;
          M_LINE_CMT:    if (c == CH_LF) m = M_NORMAL;
          M_BLOCK_CMT:   if (c == "*" && nx == "/") m = M_SKIP_NORMAL;
          M_IDENT, M_NUMBER: begin
            if ((mode_r == M_IDENT) ? is_ident(c) : is_digit(c)) begin
              if (tlen_r < TLW'(MAX_TEXT)) begin
                ram_we = 1'b1; ram_waddr = tlen_r[AW-1:0];
              end
              if (tlen_r <= TLW'(MAX_TEXT)) tlen_nxt = tlen_r + TLW'(1);
              for (int k = 0; k < KW_N; k++)
                kwm_nxt[k] = kwm_r[k] && tlen_r < TLW'(9) &&
                             kw_char(k, tlen_r[3:0]) == c;
            end else begin
              do_flush = 1'b1; proceed = 1'b1; m = M_NORMAL;
            end
          end
          default: begin
            proceed = 1'b1; m = M_NORMAL;
          end
        endcase
        if (do_flush) begin
          kw = (mode_r == M_IDENT) ? kw_hit(kwm_r, tlen_r) : K_EOF;
          f_act_nxt = 1'b1; f_iskw_nxt = (kw != K_EOF);
          f_kind_nxt = (kw != K_EOF) ? kw : ((mode_r == M_IDENT) ? K_IDENT : K_INT);
          f_cnt_nxt = (tlen_r > TLW'(MAX_TEXT)) ? TLW'(MAX_TEXT) : tlen_r;
          f_line_nxt = tok_line_r; f_col_nxt = tok_col_r;
        end
        if (proceed) begin
          s_line_nxt = cur_line_r; s_col_nxt = cur_col_r; s_char_nxt = 8'd0;
          if (c == "/" && nx == "/") begin
            m = M_LINE_CMT;
          end else if (c == "/" && nx == "*") begin
            tok_line_nxt = cur_line_r; tok_col_nxt = cur_col_r; m = M_SKIP_BLOCK;
          end else if (is_space(c)) begin
            m = M_NORMAL;
          end else if (is_alpha(c) || c == "_" || is_digit(c)) begin
            started = 1'b1;
            m = is_digit(c) ? M_NUMBER : M_IDENT;
            tok_line_nxt = cur_line_r; tok_col_nxt = cur_col_r; tlen_nxt = TLW'(1);
            for (int k = 0; k < KW_N; k++) kwm_nxt[k] = (kw_char(k, 4'd0) == c);
            if (do_flush) pw_nxt = 1'b1;
            else ram_we = 1'b1;
          end else if (tc != K_EOF) begin
            m = M_SKIP_NORMAL; s_act_nxt = 1'b1; s_kind_nxt = tc;
          end else begin
            s_act_nxt = 1'b1; s_kind_nxt = (oc != K_EOF) ? oc : K_BAD;
          end
        end
        mode_nxt = m;
        if (c == CH_LF) begin
          cur_line_nxt = sat_inc(cur_line_r); cur_col_nxt = 16'd1;
        end else begin
          cur_col_nxt = sat_inc(cur_col_r);
        end
        held_nxt = nx;
        if (nx == 8'd0) begin
          if (m == M_IDENT || m == M_NUMBER) begin
            if (started) begin
              s_act_nxt = 1'b1; s_kind_nxt = (m == M_IDENT) ? K_IDENT : K_INT;
              s_char_nxt = c;
            end else begin
              kw = (m == M_IDENT) ? kw_hit(kwm_nxt, tlen_nxt) : K_EOF;
              f_act_nxt = 1'b1; f_iskw_nxt = (kw != K_EOF);
              f_kind_nxt = (kw != K_EOF) ? kw : ((m == M_IDENT) ? K_IDENT : K_INT);
              f_cnt_nxt = (tlen_nxt > TLW'(MAX_TEXT)) ? TLW'(MAX_TEXT) : tlen_nxt;
              f_line_nxt = tok_line_r; f_col_nxt = tok_col_r;
            end
          end else if (m == M_BLOCK_CMT || m == M_SKIP_BLOCK) begin
            s_act_nxt = 1'b1; s_kind_nxt = K_OPEN_CMT; s_char_nxt = 8'd0;
            s_line_nxt = tok_line_nxt; s_col_nxt = tok_col_nxt;
          end
          e_act_nxt = 1'b1; e_line_nxt = cur_line_nxt; e_col_nxt = cur_col_nxt;
          mode_nxt = M_IDLE; held_nxt = 8'd0; tlen_nxt = '0;
          tok_line_nxt = 16'd1; tok_col_nxt = 16'd1;
          cur_line_nxt = 16'd1; cur_col_nxt = 16'd1;
        end
      end
    end else if (st_r == ST_RUN) begin
      rd_ok_nxt = 1'b1;
      if (f_act_r) begin
        if (out_free && (f_iskw_r || rd_ok_r)) begin
          out_valid_nxt = 1'b1; out_kind_nxt = f_kind_r;
          out_line_nxt = f_line_r; out_col_nxt = f_col_r;
          out_char_nxt = f_iskw_r ? 8'd0 : ram_rdata;
          out_last_nxt = f_iskw_r || (f_idx_r + TLW'(1) == f_cnt_r);
          if (out_last_nxt) f_act_nxt = 1'b0;
          f_idx_nxt = f_idx_r + TLW'(1); rd_ok_nxt = 1'b0;
        end
      end else if (pw_r) begin
        ram_we = 1'b1; ram_wdata = pw_data_r; pw_nxt = 1'b0;
      end else if (s_act_r) begin
        if (out_free) begin
          out_valid_nxt = 1'b1; out_kind_nxt = s_kind_r; out_line_nxt = s_line_r;
          out_col_nxt = s_col_r; out_char_nxt = s_char_r; out_last_nxt = 1'b1;
          s_act_nxt = 1'b0;
        end
      end else if (e_act_r) begin
        if (out_free) begin
          out_valid_nxt = 1'b1; out_kind_nxt = K_EOF; out_line_nxt = e_line_r;
          out_col_nxt = e_col_r; out_char_nxt = 8'd0; out_last_nxt = 1'b1;
          e_act_nxt = 1'b0;
        end
      end else begin
        st_nxt = ST_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; mode_r <= M_IDLE; held_r <= 8'd0; tlen_r <= '0;
      tok_line_r <= 16'd1; tok_col_r <= 16'd1; cur_line_r <= 16'd1; cur_col_r <= 16'd1;
      f_act_r <= 1'b0; s_act_r <= 1'b0; e_act_r <= 1'b0; pw_r <= 1'b0;
      rd_ok_r <= 1'b0; out_valid_r <= 1'b0; f_idx_r <= '0;
    end else begin
      st_r <= st_nxt; mode_r <= mode_nxt; held_r <= held_nxt; tlen_r <= tlen_nxt;
      tok_line_r <= tok_line_nxt; tok_col_r <= tok_col_nxt;
      cur_line_r <= cur_line_nxt; cur_col_r <= cur_col_nxt;
      f_act_r <= f_act_nxt; s_act_r <= s_act_nxt; e_act_r <= e_act_nxt; pw_r <= pw_nxt;
      rd_ok_r <= rd_ok_nxt; out_valid_r <= out_valid_nxt; f_idx_r <= f_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kwm_r <= kwm_nxt; f_iskw_r <= f_iskw_nxt; f_kind_r <= f_kind_nxt; f_cnt_r <= f_cnt_nxt;
    f_line_r <= f_line_nxt; f_col_r <= f_col_nxt; pw_data_r <= pw_data_nxt;
    s_kind_r <= s_kind_nxt; s_char_r <= s_char_nxt; s_line_r <= s_line_nxt;
    s_col_r <= s_col_nxt; e_line_r <= e_line_nxt; e_col_r <= e_col_nxt;
    out_last_r <= out_last_nxt; out_kind_r <= out_kind_nxt; out_line_r <= out_line_nxt;
    out_col_r <= out_col_nxt; out_char_r <= out_char_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast = out_last_r;
  assign out_tdata = {2'b00, out_char_r, out_col_r, out_line_r, out_kind_r};

`include "c_subset_lexer_assert.svh"
  `CSL_IMPLY(a_idle_empty, st_r == ST_IDLE, !f_act_r && !s_act_r && !e_act_r && !pw_r)
  `CSL_IMPLY(a_flush_idx, f_act_r && !f_iskw_r, f_idx_r < f_cnt_r)
  `CSL_IMPLY(a_flush_cnt, f_act_r, f_cnt_r <= TLW'(MAX_TEXT) && f_cnt_r != '0)
  `CSL_NEXT(a_eof_reset, in_acc && in_tdata == 8'd0, mode_r == M_IDLE && e_act_r)
endmodule
